[hdl/ptpd_pkg.sv]
// ----------------------------------------------------------------------------
// ptpd_pkg
// Shared widths, types and constants of the point transform pipeline.
// ----------------------------------------------------------------------------
package ptpd_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int OUT_W      = 32;
  localparam int COEF_W     = 32;
  localparam int CFG_W      = 64;
  localparam int CFG_REGS   = 8;
  localparam int CFG_IDX_W  = $clog2(CFG_REGS);

  // product, scaled product, row sum and divider widths
  localparam int PROD_W = COEF_W + COORD_WIDTH;
  localparam int SCL_W  = PROD_W - FRAC_BITS;
  localparam int SUM_W  = ((SCL_W > COEF_W) ? SCL_W : COEF_W) + 2;
  localparam int MAG_W  = SUM_W;
  localparam int QW     = COORD_WIDTH;
  localparam int REM_W  = MAG_W + ((COORD_WIDTH > FRAC_BITS) ? COORD_WIDTH : FRAC_BITS);

  // stages: product, row sum, then the divider
  localparam int DIV_LAT = QW + 3;
  localparam int LAT     = DIV_LAT + 2;

  localparam logic [OUT_W-1:0] SAT_MAX = OUT_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic [OUT_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef logic [3:0][3:0][COEF_W-1:0] coef_mat_t;
  typedef logic [3:0][SUM_W-1:0]       row_sums_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [MAG_W-1:0] den;
    logic [QW-1:0]    quo;
    logic             ovf;
    logic             neg;
    logic             zero;
  } div_stage_t;

  typedef struct packed {
    logic [OUT_W-1:0] proj;
    logic             clip;
    logic             zero;
  } div_result_t;

endpackage

[hdl/ptpd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ptpd_cfg_regs
// Matrix register file, eight 64-bit registers holding two coefficients each.
// ----------------------------------------------------------------------------
module ptpd_cfg_regs
  import ptpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output coef_mat_t            coef
);

  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_C01 = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_C23 = CFG_IDX_W'(7);
  localparam logic [COEF_W-1:0]    ONE          = COEF_W'(64'd1 << FRAC_BITS);
  localparam logic [COEF_W-1:0]    NIL          = '0;

  logic [CFG_REGS-1:0][CFG_W-1:0] regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      // identity matrix
      regs[REG_ROW0_C01] <= {NIL, ONE};
      regs[REG_ROW0_C23] <= '0;
      regs[REG_ROW1_C01] <= {ONE, NIL};
      regs[REG_ROW1_C23] <= '0;
      regs[REG_ROW2_C01] <= '0;
      regs[REG_ROW2_C23] <= {NIL, ONE};
      regs[REG_ROW3_C01] <= '0;
      regs[REG_ROW3_C23] <= {ONE, NIL};
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_wdata;
    end
  end

  // register r*2 + c/2 holds m[r][c] in half c%2, the packed matrix order
  assign coef = regs;

endmodule

[hdl/ptpd_rowsum.sv]
// ----------------------------------------------------------------------------
// ptpd_rowsum
// Two-stage matrix by point product: registered products, then row sums.
// ----------------------------------------------------------------------------
module ptpd_rowsum
  import ptpd_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  coef_mat_t        coef,
  input  logic [OUT_W-1:0] point_x,
  input  logic [OUT_W-1:0] point_y,
  input  logic [OUT_W-1:0] point_z,
  output row_sums_t        sums
);

  logic [3:0][2:0][PROD_W-1:0] prod;
  logic [2:0][COORD_WIDTH-1:0] pt;
  row_sums_t                   sums_next;

  assign pt[0] = point_x[COORD_WIDTH-1:0];
  assign pt[1] = point_y[COORD_WIDTH-1:0];
  assign pt[2] = point_z[COORD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= PROD_W'(signed'(coef[r][c]) * signed'(pt[c]));
        end
      end
    end
  end

  // floor scaling is the arithmetic drop of the fraction bits
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      logic signed [SUM_W-1:0] acc;
      acc = SUM_W'(signed'(coef[r][3]));
      for (int c = 0; c < 3; c++) begin
        acc = acc + SUM_W'(signed'(prod[r][c][PROD_W-1:FRAC_BITS]));
      end
      sums_next[r] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sums <= sums_next;
    end
  end

endmodule

[hdl/ptpd_divider.sv]
// ----------------------------------------------------------------------------
// ptpd_divider
// Pipelined saturating fixed-point divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptpd_divider
  import ptpd_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [SUM_W-1:0] num,
  input  logic [SUM_W-1:0] den,
  output div_result_t      res
);

  localparam logic [QW-1:0] LIM_POS = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = {1'b1, {(QW-1){1'b0}}};

  logic [MAG_W-1:0] num_mag;
  logic [MAG_W-1:0] den_mag;
  logic             neg;
  logic             zero;
  div_stage_t       pipe [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      num_mag <= num[SUM_W-1] ? MAG_W'(~num + 1'b1) : MAG_W'(num);
      den_mag <= den[SUM_W-1] ? MAG_W'(~den + 1'b1) : MAG_W'(den);
      neg     <= num[SUM_W-1] ^ den[SUM_W-1];
      zero    <= (den == '0);
    end
  end

  // quotient of at least 2^QW saturates whatever the fraction bits say
  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0].rem  <= REM_W'(num_mag) << FRAC_BITS;
      pipe[0].den  <= den_mag;
      pipe[0].quo  <= '0;
      pipe[0].ovf  <= (REM_W'(num_mag) << FRAC_BITS) >= (REM_W'(den_mag) << QW);
      pipe[0].neg  <= neg;
      pipe[0].zero <= zero;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int BIT = QW - 1 - k;
    logic [REM_W:0] diff;
    div_stage_t     stage_next;
    assign diff = {1'b0, pipe[k].rem} - {1'b0, REM_W'(pipe[k].den) << BIT};

    always_comb begin
      stage_next = pipe[k];
      if (!diff[REM_W]) begin
        stage_next.rem      = diff[REM_W-1:0];
        stage_next.quo[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[k+1] <= stage_next;
      end
    end
  end

  logic [QW-1:0] lim;
  logic          sat;
  logic [QW-1:0] mag;
  logic [QW-1:0] sgn;

  always_comb begin
    lim = pipe[QW].neg ? LIM_NEG : LIM_POS;
    sat = pipe[QW].ovf || (pipe[QW].quo > lim);
    mag = sat ? lim : pipe[QW].quo;
    sgn = pipe[QW].neg ? QW'(~mag + 1'b1) : mag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.zero <= pipe[QW].zero;
      res.clip <= sat && !pipe[QW].zero;
      res.proj <= pipe[QW].zero ? '0 : OUT_W'(signed'(sgn));
    end
  end

endmodule

[hdl/point_transform_perspective_divide_top.sv]
// ----------------------------------------------------------------------------
// point_transform_perspective_divide_top
// 4x4 homogeneous point transform followed by a saturating perspective divide.
// ----------------------------------------------------------------------------
// Input beats carry point_x/y/z on in_valid/in_ready; result beats carry
// proj_x/y/z, w_was_zero and clipped on out_valid/out_ready.
// The matrix sits in eight 64-bit registers written through cfg_we,
// cfg_index and cfg_wdata; write them only while no beat is in flight.
// Pipeline stages, in order: one product stage, one row-sum stage, abs and
// range check stages, one stage per quotient bit in each of the three lane
// dividers, and the output register. Throughput is one point per cycle
// unless the output stalls. The pipeline advances as a whole; when the
// receiver holds out_ready low with a result waiting, every stage holds and
// in_ready drops in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits and loads the identity matrix.
// Zero w gives zero outputs with w_was_zero set; quotients outside the
// coordinate range saturate and set clipped.
// ----------------------------------------------------------------------------
module point_transform_perspective_divide_top
  import ptpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OUT_W-1:0]     point_x,
  input  logic [OUT_W-1:0]     point_y,
  input  logic [OUT_W-1:0]     point_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_W-1:0]     proj_x,
  output logic [OUT_W-1:0]     proj_y,
  output logic [OUT_W-1:0]     proj_z,
  output logic                 w_was_zero,
  output logic                 clipped,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  coef_mat_t        coef;
  row_sums_t        sums;
  div_result_t      lane [3];
  logic [LAT-1:0]   vld;
  logic             en;

  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  ptpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  ptpd_rowsum u_rowsum (
    .clk     (clk),
    .en      (en),
    .coef    (coef),
    .point_x (point_x),
    .point_y (point_y),
    .point_z (point_z),
    .sums    (sums)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ptpd_divider u_div (
      .clk (clk),
      .en  (en),
      .num (sums[i]),
      .den (sums[3]),
      .res (lane[i])
    );
  end

  assign proj_x     = lane[0].proj;
  assign proj_y     = lane[1].proj;
  assign proj_z     = lane[2].proj;
  assign w_was_zero = lane[0].zero;
  assign clipped    = lane[0].clip | lane[1].clip | lane[2].clip;

  a_zero_w_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && w_was_zero |->
      proj_x == '0 && proj_y == '0 && proj_z == '0 && !clipped)
    else $error("zero w result not cleared");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      proj_x == SAT_MAX || proj_x == SAT_MIN || proj_y == SAT_MAX ||
      proj_y == SAT_MIN || proj_z == SAT_MAX || proj_z == SAT_MIN)
    else $error("clipped set with no saturated coordinate");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule
